[hdl/strmax_pkg.sv]
// Shared constants, operation codes and helpers for the range-maximum segment tree.
package strmax_pkg;

   localparam int IDX_W  = 11;
   localparam int DATA_W = 32;
   localparam int OP_W   = 2;

   localparam logic [OP_W-1:0] OP_LOAD  = 2'd0;
   localparam logic [OP_W-1:0] OP_ADD   = 2'd1;
   localparam logic [OP_W-1:0] OP_SUB   = 2'd2;
   localparam logic [OP_W-1:0] OP_QUERY = 2'd3;

   // most negative value, identity of the signed max
   localparam logic [DATA_W-1:0] DATA_MIN = {1'b1, {(DATA_W-1){1'b0}}};

   typedef logic [IDX_W-1:0]  idx_type;
   typedef logic [DATA_W-1:0] data_type;

   // signed max, first argument wins a tie
   function automatic data_type smax(input data_type a, input data_type b);
      smax = ($signed(a) >= $signed(b)) ? a : b;
   endfunction

endpackage

[hdl/segment_tree_range_max.sv]
// Range-maximum segment tree with point load, add and subtract, one node memory, one access at a time.
//
// Usage: pulse start with the request fields while busy is low; the request is
// transferred on that edge. Every element 1..element_count must be loaded (op 0) before
// the first add, subtract or query; the tree storage has no reset and reads garbage until
// written. A query (op 3) gives exactly one transfer on rsp_strobe/rsp_range_max; the
// strobe is high for one cycle and cannot be held off. Updates give no response, and an
// update whose position is 0 or beyond the element count is dropped in the request cycle.
// An update walks down to the leaf; a load writes the leaf, an add or subtract reads it
// and then writes the sum or difference. The ascent then needs two child reads and one
// parent write per level, each in its own state, as the sequencer makes one node memory
// access at a time. A query takes one node step per state down each edge of the range,
// at most one memory read per step, plus a drain state that folds the last read. An
// empty query range answers 0x80000000 in the cycle after its transfer. element_count is
// written through the csr channel while the block is idle; 0 acts as 1 and values above
// MAX_ELEMENTS act as MAX_ELEMENTS.
module segment_tree_range_max #(
   parameter int MAX_ELEMENTS = 1024,
   parameter int TREE_NODES   = 4096
) (
   input  logic                          clock,
   input  logic                          reset,
   // request channel
   input  logic                          start,
   output logic                          busy,
   input  logic [strmax_pkg::OP_W-1:0]   req_op,
   input  logic [strmax_pkg::IDX_W-1:0]  req_position,
   input  logic signed [strmax_pkg::DATA_W-1:0] req_amount,
   input  logic [strmax_pkg::IDX_W-1:0]  req_query_low,
   input  logic [strmax_pkg::IDX_W-1:0]  req_query_high,
   // response channel
   output logic                          rsp_strobe,
   output logic signed [strmax_pkg::DATA_W-1:0] rsp_range_max,
   // configuration channel
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [strmax_pkg::IDX_W-1:0]  csr_element_count
);
   import strmax_pkg::*;

   // memory address width, and node index width (heap index stays below 4 * count)
   localparam int AW  = $clog2(TREE_NODES);
   localparam int EW  = $clog2(MAX_ELEMENTS) + 2;
   localparam int NW  = (EW > AW) ? EW : AW;
   localparam logic [NW:0] NODE_LIMIT = (NW+1)'(TREE_NODES);

   // sequencer states
   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_DESC  = 4'd1;  // walk down to the leaf
   localparam logic [3:0] ST_LEAF  = 4'd2;  // leaf data back, write sum/difference
   localparam logic [3:0] ST_RD_L  = 4'd3;  // ascent: read left child
   localparam logic [3:0] ST_RD_R  = 4'd4;  // ascent: read right child
   localparam logic [3:0] ST_WR    = 4'd5;  // ascent: write parent max
   localparam logic [3:0] ST_QROOT = 4'd6;  // query: above the split node
   localparam logic [3:0] ST_QLEFT = 4'd7;  // query: left edge, right-aligned ranges
   localparam logic [3:0] ST_QRGHT = 4'd8;  // query: right edge, left-aligned ranges
   localparam logic [3:0] ST_DRAIN = 4'd9;  // fold last read and respond

   typedef logic [NW-1:0] node_type;

   logic [3:0]      state_ff, state_in;
   logic [OP_W-1:0] op_ff, op_in;
   data_type        amt_ff, amt_in;
   node_type        node_ff, node_in;
   idx_type         lo_ff, lo_in, hi_ff, hi_in;
   idx_type         ql_ff, ql_in, qh_ff, qh_in;
   node_type        sv_node_ff, sv_node_in;
   idx_type         sv_lo_ff, sv_lo_in, sv_hi_ff, sv_hi_in;
   data_type        acc_ff, acc_in;
   data_type        left_ff, left_in;
   logic            pend_ff, pend_in;
   logic            oob_ff;
   data_type        rdata_ff;
   logic            rsp_valid_ff, rsp_valid_in;
   data_type        rsp_max_ff, rsp_max_in;
   idx_type         count_ff;

   data_type        mem [TREE_NODES];

   logic            rd_en, wr_en;
   node_type        rd_node, wr_node;
   data_type        wr_data, rd_data;
   logic            rd_ok, wr_ok;

   idx_type         n_act, mid, ql_cl, qh_cl;
   logic [IDX_W:0]  lo_hi_sum;
   node_type        child_l, child_r;
   logic            accept, narrow;

   // ---------------------------------------------------------------- element count
   always_comb begin
      if (count_ff == '0) begin
         n_act = idx_type'(1);
      end else if (32'(count_ff) > MAX_ELEMENTS) begin
         n_act = idx_type'(MAX_ELEMENTS);
      end else begin
         n_act = count_ff;
      end
   end

   assign lo_hi_sum = {1'b0, lo_ff} + {1'b0, hi_ff};
   assign mid       = lo_hi_sum[IDX_W:1];
   assign child_l   = {node_ff[NW-2:0], 1'b0};
   assign child_r   = {node_ff[NW-2:0], 1'b1};
   assign narrow    = (lo_ff < hi_ff);

   // nodes beyond storage read as zero, writes to them vanish
   assign rd_ok   = ({1'b0, rd_node} < NODE_LIMIT);
   assign wr_ok   = ({1'b0, wr_node} < NODE_LIMIT);
   assign rd_data = oob_ff ? '0 : rdata_ff;

   assign busy      = (state_ff != ST_IDLE);
   assign accept    = start && !busy;
   assign csr_ready = !busy;

   assign ql_cl = (req_query_low == '0) ? idx_type'(1) : req_query_low;
   assign qh_cl = (req_query_high > n_act) ? n_act : req_query_high;

   // ---------------------------------------------------------------- sequencer
   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      amt_in       = amt_ff;
      node_in      = node_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      ql_in        = ql_ff;
      qh_in        = qh_ff;
      sv_node_in   = sv_node_ff;
      sv_lo_in     = sv_lo_ff;
      sv_hi_in     = sv_hi_ff;
      left_in      = left_ff;
      pend_in      = 1'b0;
      rsp_valid_in = 1'b0;
      rsp_max_in   = rsp_max_ff;
      rd_en        = 1'b0;
      rd_node      = node_ff;
      wr_en        = 1'b0;
      wr_node      = node_ff;
      wr_data      = amt_ff;

      // query reads land in the next cycle and fold into the running max
      acc_in = pend_ff ? smax(acc_ff, rd_data) : acc_ff;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               op_in   = req_op;
               amt_in  = data_type'(req_amount);
               node_in = node_type'(1);
               lo_in   = idx_type'(1);
               hi_in   = n_act;
               if (req_op == OP_QUERY) begin
                  ql_in  = ql_cl;
                  qh_in  = qh_cl;
                  acc_in = DATA_MIN;
                  if (ql_cl > qh_cl) begin
                     rsp_valid_in = 1'b1;
                     rsp_max_in   = DATA_MIN;
                  end else begin
                     state_in = ST_QROOT;
                  end
               end else if (req_position != '0 && req_position <= n_act) begin
                  ql_in    = req_position;
                  state_in = ST_DESC;
               end
            end
         end

         ST_DESC: begin
            // position is held in ql_ff during updates
            if (narrow) begin
               if (ql_ff <= mid) begin
                  node_in = child_l;
                  hi_in   = mid;
               end else begin
                  node_in = child_r;
                  lo_in   = mid + idx_type'(1);
               end
            end else if (op_ff == OP_LOAD) begin
               wr_en   = 1'b1;
               wr_data = amt_ff;
               node_in = node_ff >> 1;
               state_in = (node_ff == node_type'(1)) ? ST_IDLE : ST_RD_L;
            end else begin
               rd_en    = 1'b1;
               state_in = ST_LEAF;
            end
         end

         ST_LEAF: begin
            wr_en    = 1'b1;
            wr_data  = (op_ff == OP_ADD) ? rd_data + amt_ff : rd_data - amt_ff;
            node_in  = node_ff >> 1;
            state_in = (node_ff == node_type'(1)) ? ST_IDLE : ST_RD_L;
         end

         ST_RD_L: begin
            rd_en    = 1'b1;
            rd_node  = child_l;
            state_in = ST_RD_R;
         end

         ST_RD_R: begin
            rd_en    = 1'b1;
            rd_node  = child_r;
            left_in  = rd_data;
            state_in = ST_WR;
         end

         ST_WR: begin
            wr_en    = 1'b1;
            wr_data  = smax(left_ff, rd_data);
            node_in  = node_ff >> 1;
            state_in = (node_ff == node_type'(1)) ? ST_IDLE : ST_RD_L;
         end

         ST_QROOT: begin
            if ((ql_ff == lo_ff && qh_ff == hi_ff) || !narrow) begin
               rd_en    = 1'b1;
               pend_in  = 1'b1;
               state_in = ST_DRAIN;
            end else if (qh_ff <= mid) begin
               node_in = child_l;
               hi_in   = mid;
            end else if (ql_ff > mid) begin
               node_in = child_r;
               lo_in   = mid + idx_type'(1);
            end else begin
               // split: keep the right child for later, follow the left edge now
               sv_node_in = child_r;
               sv_lo_in   = mid + idx_type'(1);
               sv_hi_in   = hi_ff;
               node_in    = child_l;
               hi_in      = mid;
               state_in   = ST_QLEFT;
            end
         end

         ST_QLEFT: begin
            if (ql_ff == lo_ff || !narrow) begin
               rd_en    = 1'b1;
               pend_in  = 1'b1;
               node_in  = sv_node_ff;
               lo_in    = sv_lo_ff;
               hi_in    = sv_hi_ff;
               state_in = ST_QRGHT;
            end else if (ql_ff > mid) begin
               node_in = child_r;
               lo_in   = mid + idx_type'(1);
            end else begin
               // right half fully covered
               rd_en   = 1'b1;
               rd_node = child_r;
               pend_in = 1'b1;
               node_in = child_l;
               hi_in   = mid;
            end
         end

         ST_QRGHT: begin
            if (qh_ff == hi_ff || !narrow) begin
               rd_en    = 1'b1;
               pend_in  = 1'b1;
               state_in = ST_DRAIN;
            end else if (qh_ff <= mid) begin
               node_in = child_l;
               hi_in   = mid;
            end else begin
               // left half fully covered
               rd_en   = 1'b1;
               rd_node = child_l;
               pend_in = 1'b1;
               node_in = child_r;
               lo_in   = mid + idx_type'(1);
            end
         end

         ST_DRAIN: begin
            rsp_valid_in = 1'b1;
            rsp_max_in   = acc_in;
            state_in     = ST_IDLE;
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // ---------------------------------------------------------------- node memory
   always_ff @(posedge clock) begin
      if (wr_en && wr_ok) begin
         mem[wr_node[AW-1:0]] <= wr_data;
      end
      if (rd_en) begin
         rdata_ff <= mem[rd_node[AW-1:0]];
         oob_ff   <= !rd_ok;
      end
   end

   // ---------------------------------------------------------------- registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         count_ff     <= idx_type'(1);
      end else begin
         state_ff     <= state_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            count_ff <= csr_element_count;
         end
      end
   end

   always_ff @(posedge clock) begin
      op_ff      <= op_in;
      amt_ff     <= amt_in;
      node_ff    <= node_in;
      lo_ff      <= lo_in;
      hi_ff      <= hi_in;
      ql_ff      <= ql_in;
      qh_ff      <= qh_in;
      sv_node_ff <= sv_node_in;
      sv_lo_ff   <= sv_lo_in;
      sv_hi_ff   <= sv_hi_in;
      acc_ff     <= acc_in;
      left_ff    <= left_in;
      rsp_max_ff <= rsp_max_in;
   end

   assign rsp_strobe    = rsp_valid_ff;
   assign rsp_range_max = $signed(rsp_max_ff);

endmodule

[tb/tb_segment_tree_range_max.sv]
// Self-checking testbench for segment_tree_range_max: directed, random and full-size runs.
module tb_segment_tree_range_max;
   timeunit 1ns;
   timeprecision 1ps;

   import strmax_pkg::*;

   // Updates give no response, so before a register write we let the longest update
   // (at 1024 elements) finish.
   localparam int SETTLE_CYCLES = 64;
   localparam int NODE_COUNT    = 4096;
   localparam int TOP_COUNT     = 1024;
   localparam int FIELD_TOP     = 2047;   // all ones in an 11-bit index field

   logic                      clock             = 1'b0;
   logic                      reset             = 1'b1;
   logic                      start             = 1'b0;
   logic                      busy;
   logic [OP_W-1:0]           req_op            = OP_LOAD;
   idx_type                   req_position      = '0;
   logic signed [DATA_W-1:0]  req_amount        = '0;
   idx_type                   req_query_low     = '0;
   idx_type                   req_query_high    = '0;
   logic                      rsp_strobe;
   logic signed [DATA_W-1:0]  rsp_range_max;
   logic                      csr_valid         = 1'b0;
   logic                      csr_ready;
   idx_type                   csr_element_count = '0;

   segment_tree_range_max dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_op            (req_op),
      .req_position      (req_position),
      .req_amount        (req_amount),
      .req_query_low     (req_query_low),
      .req_query_high    (req_query_high),
      .rsp_strobe        (rsp_strobe),
      .rsp_range_max     (rsp_range_max),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_element_count (csr_element_count)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Shadow tree: same heap layout as the block, node 1 covers 1..span.
   data_type tree_max [0:NODE_COUNT-1] = '{default: '0};
   int       span = 1;               // element count in effect (0 -> 1, clipped to 1024)
   data_type pending_max_q [$];      // expected answers of queries still in flight

   int  items_done    = 0;           // transfers that did real work
   int  results_seen  = 0;
   int  errors        = 0;
   int  settings_used = 0;
   int  widest        = 1;
   bit  idle_on       = 1'b1;        // sender gaps enabled

   // Point load/add/subtract on element pos, then refresh its ancestors.
   function automatic void apply_point_change(input logic [OP_W-1:0] op, input int pos,
                                              input data_type amt);
      int       trail [40];
      int       depth;
      int       node;
      int       lo;
      int       hi;
      int       mid;
      data_type left;
      data_type right;
      depth = 0;
      node  = 1;
      lo    = 1;
      hi    = span;
      while (lo < hi) begin
         mid          = (lo + hi) / 2;
         trail[depth] = node;
         depth++;
         if (pos <= mid) begin
            node = 2 * node;
            hi   = mid;
         end else begin
            node = 2 * node + 1;
            lo   = mid + 1;
         end
      end
      case (op)
         OP_LOAD: tree_max[node] = amt;
         OP_ADD:  tree_max[node] = tree_max[node] + amt;   // wraps at 32 bits
         default: tree_max[node] = tree_max[node] - amt;
      endcase
      for (int i = depth - 1; i >= 0; i--) begin
         left  = tree_max[2 * trail[i]];
         right = tree_max[2 * trail[i] + 1];
         tree_max[trail[i]] = ($signed(right) > $signed(left)) ? right : left;
      end
   endfunction

   // Signed maximum over ql..qh (already clipped, non-empty); explicit stack walk.
   function automatic data_type range_max_over(input int ql, input int qh);
      int       nd  [64];
      int       los [64];
      int       his [64];
      int       qls [64];
      int       qhs [64];
      int       sp;
      int       node;
      int       lo;
      int       hi;
      int       a;
      int       b;
      int       mid;
      data_type best;
      best   = DATA_MIN;
      sp     = 1;
      nd[0]  = 1;
      los[0] = 1;
      his[0] = span;
      qls[0] = ql;
      qhs[0] = qh;
      while (sp > 0) begin
         sp--;
         node = nd[sp];
         lo   = los[sp];
         hi   = his[sp];
         a    = qls[sp];
         b    = qhs[sp];
         if ((a == lo && b == hi) || lo >= hi) begin
            if ($signed(tree_max[node]) > $signed(best)) best = tree_max[node];
         end else begin
            mid = (lo + hi) / 2;
            if (a <= mid) begin
               nd[sp]  = 2 * node;
               los[sp] = lo;
               his[sp] = mid;
               qls[sp] = a;
               qhs[sp] = (b < mid) ? b : mid;
               sp++;
            end
            if (b > mid) begin
               nd[sp]  = 2 * node + 1;
               los[sp] = mid + 1;
               his[sp] = hi;
               qls[sp] = (a > mid) ? a : mid + 1;
               qhs[sp] = b;
               sp++;
            end
         end
      end
      return best;
   endfunction

   // Mostly full-range random, with a share of wrap-prone extremes and small values.
   function automatic data_type random_amount();
      case ($urandom_range(0, 7))
         0: begin
            case ($urandom_range(0, 4))
               0:       return 32'h7FFF_FFFF;
               1:       return DATA_MIN;
               2:       return 32'h0000_0000;
               3:       return 32'h0000_0001;
               default: return 32'hFFFF_FFFF;
            endcase
         end
         1, 2:    return data_type'($urandom_range(0, 200)) - 32'd100;
         default: return $urandom;
      endcase
   endfunction

   // One request transfer. Called at a rising edge; returns at the edge of the transfer
   // with start still high, so the next call can keep it high with no glitch.
   task automatic send_request(input logic [OP_W-1:0] op, input int pos, input data_type amt,
                               input int ql, input int qh);
      int lo;
      int hi;
      if (idle_on && $urandom_range(0, 4) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 17)) @(posedge clock);
      end
      start          <= 1'b1;
      req_op         <= op;
      req_position   <= idx_type'(pos);
      req_amount     <= amt;
      req_query_low  <= idx_type'(ql);
      req_query_high <= idx_type'(qh);
      @(posedge clock);
      while (busy) @(posedge clock);
      // transfer happened at this edge
      if (op == OP_QUERY) begin
         lo = (ql == 0) ? 1 : ql;
         hi = (qh > span) ? span : qh;
         pending_max_q.push_back((lo > hi) ? DATA_MIN : range_max_over(lo, hi));
         items_done++;
      end else if (pos >= 1 && pos <= span) begin
         apply_point_change(op, pos, amt);
         items_done++;
      end
   endtask

   // Drop start and wait for every outstanding answer; optionally let updates finish.
   task automatic wait_results(input bit settle);
      start <= 1'b0;
      @(posedge clock);
      while (pending_max_q.size() != 0) @(posedge clock);
      if (settle) repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Register write, only with the block idle.
   task automatic set_element_count(input idx_type value);
      wait_results(1'b1);
      csr_valid         <= 1'b1;
      csr_element_count <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      span = (value == 0) ? 1 : ((value > TOP_COUNT) ? TOP_COUNT : int'(value));
      settings_used++;
      if (span > widest) widest = span;
   endtask

   // Every element must be written before it is read: load them all in shuffled order.
   task automatic load_all();
      int order [$];
      int j;
      int t;
      for (int i = 1; i <= span; i++) order.push_back(i);
      for (int i = span - 1; i > 0; i--) begin
         j        = $urandom_range(0, i);
         t        = order[i];
         order[i] = order[j];
         order[j] = t;
      end
      foreach (order[k])
         send_request(OP_LOAD, order[k], random_amount(), $urandom_range(0, FIELD_TOP),
                      $urandom_range(0, FIELD_TOP));
   endtask

   // Random mix on a fully loaded tree: queries of all shapes, updates, dropped updates.
   task automatic run_ops(input int ops, input bit pause_on_query);
      int              r;
      int              pos;
      int              ql;
      int              qh;
      logic [OP_W-1:0] op;
      for (int k = 0; k < ops; k++) begin
         r   = $urandom_range(0, 99);
         pos = $urandom_range(1, span);
         ql  = $urandom_range(0, FIELD_TOP);
         qh  = $urandom_range(0, FIELD_TOP);
         if (r < 40) begin
            op  = OP_QUERY;
            pos = $urandom_range(0, FIELD_TOP);   // unused by a query
            case ($urandom_range(0, 9))
               0: begin                            // low bound 0 counts as 1
                  ql = 0;
                  qh = $urandom_range(0, span);
               end
               1: begin                            // high bound at or past the end
                  ql = $urandom_range(1, span);
                  qh = $urandom_range(span, FIELD_TOP);
               end
               2: begin                            // inverted range
                  ql = $urandom_range(1, FIELD_TOP);
                  qh = $urandom_range(0, ql - 1);
               end
               3: ql = $urandom_range(span + 1, FIELD_TOP);   // starts past the end
               default: begin
                  ql = $urandom_range(1, span);
                  qh = $urandom_range(ql, span);
               end
            endcase
         end else if (r < 60) begin
            op = OP_ADD;
         end else if (r < 80) begin
            op = OP_SUB;
         end else if (r < 94) begin
            op = OP_LOAD;
         end else begin
            // position 0 or beyond the count: block drops it
            op  = OP_W'($urandom_range(0, 2));
            pos = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(span + 1, FIELD_TOP);
         end
         send_request(op, pos, random_amount(), ql, qh);
         if (pause_on_query && op == OP_QUERY) wait_results(1'b0);
      end
   endtask

   // Reset count of one, count 0 acting as 1, then three elements; wraps and empty ranges.
   task automatic test_directed();
      idle_on = 1'b1;
      send_request(OP_LOAD, 1, 32'h7FFF_FFFF, 0, 0);
      send_request(OP_QUERY, 0, 32'h0, 1, 1);
      send_request(OP_ADD, 1, 32'h1, 0, 0);               // wraps to most negative
      send_request(OP_QUERY, 0, 32'h0, 0, FIELD_TOP);     // both bounds clipped
      send_request(OP_SUB, 1, DATA_MIN, 0, 0);
      send_request(OP_QUERY, 0, 32'h0, 1, 1);
      send_request(OP_LOAD, 0, 32'h1234_5678, 0, 0);      // dropped
      send_request(OP_ADD, 2, 32'h1, 0, 0);               // dropped, beyond count
      send_request(OP_QUERY, 0, 32'h0, 2, 1);             // empty
      set_element_count(idx_type'(0));
      send_request(OP_LOAD, 1, 32'hFFFF_FFFF, 0, 0);
      send_request(OP_QUERY, FIELD_TOP, 32'hFFFF_FFFF, 1, FIELD_TOP);
      set_element_count(idx_type'(3));
      send_request(OP_LOAD, 1, DATA_MIN, 0, 0);
      send_request(OP_LOAD, 2, 32'h7FFF_FFFF, 0, 0);
      send_request(OP_LOAD, 3, 32'h0, 0, 0);
      send_request(OP_QUERY, 0, 32'h0, 1, 3);
      send_request(OP_ADD, 2, 32'h1, 0, 0);
      send_request(OP_QUERY, 0, 32'h0, 1, 3);
      send_request(OP_SUB, 3, 32'h7FFF_FFFF, 0, 0);
      send_request(OP_QUERY, 0, 32'h0, 0, 3);
      send_request(OP_QUERY, 0, 32'h0, 3, 2);
      send_request(OP_QUERY, 0, 32'h0, 4, FIELD_TOP);
      send_request(OP_SUB, FIELD_TOP, 32'hFFFF_FFFF, 0, 0);   // dropped, all index bits set
      send_request(OP_QUERY, 0, 32'h0, 2, 3);
   endtask

   // Several small trees, each loaded in full, then a random mix; some with no gaps.
   task automatic test_random_sizes();
      while (items_done < 80) begin
         idle_on = ($urandom_range(0, 3) != 0);
         case ($urandom_range(0, 7))
            0:       set_element_count(idx_type'(0));
            1:       set_element_count(idx_type'(1));
            2:       set_element_count(idx_type'(2));
            default: set_element_count(idx_type'($urandom_range(3, 48)));
         endcase
         load_all();
         run_ops($urandom_range(8, 16), 1'b0);
      end
   endtask

   // Sender holds off after each query until its answer has come back.
   task automatic test_sender_pause();
      idle_on = 1'b1;
      set_element_count(idx_type'(9));
      load_all();
      run_ops(30, 1'b1);
   endtask

   // Count above the maximum acts as 1024; the closing mix runs back to back.
   task automatic test_full_size();
      idle_on = 1'b1;
      set_element_count(idx_type'(FIELD_TOP));
      load_all();
      idle_on = 1'b0;
      run_ops(24, 1'b0);
   endtask

   // Each answer is on the port for one cycle and is taken at the edge ending it.
   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         results_seen++;
         if (pending_max_q.size() == 0) begin
            errors++;
            $display("%0t: answer with no query outstanding, expected none, got %h",
                     $time, rsp_range_max);
         end else begin
            if (rsp_range_max !== pending_max_q[0]) begin
               errors++;
               $display("%0t: range_max mismatch, expected %h, got %h",
                        $time, pending_max_q[0], rsp_range_max);
            end
            void'(pending_max_q.pop_front());
         end
      end
   end

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_random_sizes();
      test_sender_pause();
      test_full_size();
      wait_results(1'b1);
      $display("Ran %0d working transfers over %0d count settings (up to %0d elements).",
               items_done, settings_used, widest);
      $display("Checked %0d query answers, with gaps, pauses and back-to-back traffic.",
               results_seen);
      if (errors == 0 && pending_max_q.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   // Watchdog, roughly ten times the slowest legal run.
   initial begin
      #10ms;
      $display("== FAIL ==");
      $finish;
   end

endmodule
